FILE: hdl/itp_pkg.sv
// Shared types and constants for the integer text parser.
// Used by itp_in_stage, itp_core and integer_text_parser; no dependencies.

package itp_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;
    localparam int END_W   = 13;
    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } char_word_t;

endpackage

FILE: hdl/itp_in_stage.sv
// Input skid stage of the integer text parser: a head register and a skid register.
// Depends on itp_pkg for the word type.

module itp_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  itp_pkg::char_word_t in_word,
    output logic                head_valid,
    output itp_pkg::char_word_t head_word,
    input  logic                head_take
);

    logic                head_valid_reg;
    logic                head_valid_next;
    itp_pkg::char_word_t head_word_reg;
    itp_pkg::char_word_t head_word_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    itp_pkg::char_word_t skid_word_reg;
    itp_pkg::char_word_t skid_word_next;
    logic                accept;

    assign in_ready   = !skid_valid_reg;
    assign accept     = in_valid && in_ready;
    assign head_valid = head_valid_reg;
    assign head_word  = head_word_reg;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        head_word_next  = head_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;
        if (!head_valid_reg || head_take)
        begin
            if (skid_valid_reg)
            begin
                head_valid_next = 1'b1;
                head_word_next  = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_valid_next = accept;
                head_word_next  = in_word;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_word_reg <= head_word_next;
        skid_word_reg <= skid_word_next;
    end

endmodule

FILE: hdl/itp_core.sv
// Parse state, one-character step logic and result register of the integer text parser.
// Depends on itp_pkg for widths and the word type.

module itp_core
#(
    parameter int MAX_LEN = 4096
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [itp_pkg::RADIX_W-1:0]   radix,
    input  logic                          head_valid,
    input  itp_pkg::char_word_t           head_word,
    output logic                          head_take,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [itp_pkg::VALUE_W-1:0]   out_value,
    output logic [itp_pkg::END_W-1:0]     out_end_pos
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_PREFIX = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [itp_pkg::RADIX_W-1:0] BASE_OCT = 6'd8;
    localparam logic [itp_pkg::RADIX_W-1:0] BASE_DEC = 6'd10;
    localparam logic [itp_pkg::RADIX_W-1:0] BASE_HEX = 6'd16;

    logic [2:0]                    phase_reg;
    logic [2:0]                    phase_next;
    logic                          neg_reg;
    logic                          neg_next;
    logic [itp_pkg::VALUE_W-1:0]   acc_reg;
    logic [itp_pkg::VALUE_W-1:0]   acc_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic [itp_pkg::RADIX_W-1:0]   base_reg;
    logic [itp_pkg::RADIX_W-1:0]   base_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [itp_pkg::VALUE_W-1:0]   out_value_reg;
    logic [itp_pkg::END_W-1:0]     out_end_reg;

    logic [itp_pkg::CHAR_W-1:0]    c;
    logic                          is_space;
    logic                          is_alnum;
    logic [itp_pkg::DIGIT_W-1:0]   digit;
    logic                          take_char;
    logic                          at_prefix;
    logic                          at_digits;
    logic [itp_pkg::VALUE_W-1:0]   addend;
    logic [itp_pkg::VALUE_W-1:0]   acc_step;
    logic                          step;
    logic                          emit;

    assign c = head_word.char_code;
    assign is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D)
        || (c == 8'h0C) || (c == 8'h0B);

    always_comb
    begin
        is_alnum = 1'b1;
        digit    = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            digit = 6'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            digit = 6'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h5A)
        begin
            digit = 6'(c - 8'h37);
        end
        else
        begin
            is_alnum = 1'b0;
        end
    end

    assign head_take = !head_word.is_last || !out_valid_reg || out_ready;
    assign step      = head_valid && head_take;
    assign emit      = step && head_word.is_last;

    // The sign is known before any digit, so a negative number is accumulated
    // downward and needs no negation at the end.
    assign addend   = neg_next ? (64'd0 - 64'(digit)) : 64'(digit);
    assign acc_step = 64'(acc_reg * {{(itp_pkg::VALUE_W - itp_pkg::RADIX_W){1'b0}}, base_next})
        + addend;

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        take_char  = 1'b0;
        at_prefix  = 1'b0;
        at_digits  = 1'b0;
        if (head_word.char_valid)
        begin
            if (phase_reg == PH_SPACE)
            begin
                if (is_space)
                begin
                    take_char = 1'b1;
                end
                else if (c == 8'h2B || c == 8'h2D)
                begin
                    neg_next   = (c == 8'h2D);
                    take_char  = 1'b1;
                    phase_next = PH_PREFIX;
                end
                else
                begin
                    at_prefix = 1'b1;
                end
            end
            if (phase_reg == PH_PREFIX || at_prefix)
            begin
                if (radix == '0 && c == 8'h30)
                begin
                    take_char  = 1'b1;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    base_next = (radix == '0) ? BASE_DEC : radix;
                    at_digits = 1'b1;
                end
            end
            if (phase_reg == PH_ZERO)
            begin
                if (c == 8'h78 || c == 8'h58)
                begin
                    base_next  = BASE_HEX;
                    take_char  = 1'b1;
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    base_next = BASE_OCT;
                    at_digits = 1'b1;
                end
            end
            if (phase_reg == PH_DIGITS || at_digits)
            begin
                if (!is_alnum || digit >= base_next)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    acc_next   = acc_step;
                    take_char  = 1'b1;
                    phase_next = PH_DIGITS;
                end
            end
        end
        cnt_next = (take_char && cnt_reg < CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
    end

    assign out_valid_next = emit ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SPACE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (emit)
            begin
                phase_reg <= PH_SPACE;
                neg_reg   <= 1'b0;
                acc_reg   <= '0;
                cnt_reg   <= '0;
                base_reg  <= '0;
            end
            else if (step)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                base_reg  <= base_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_value_reg <= acc_next;
            out_end_reg   <= itp_pkg::END_W'(cnt_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign out_end_pos = out_end_reg;

endmodule

FILE: hdl/integer_text_parser.sv
// Integer text parser: one character per word in, one signed 64-bit value per string out.
// A last word passes the head register, then the result register raises m_axis_tvalid.
// Throughput: one word per cycle; a last word waits only while an earlier result is unread.
// Reset (rst_n, asynchronous): radix returns to 10 and the parse state to skipping spaces.
// Depends on itp_pkg, itp_in_stage and itp_core.

module integer_text_parser
#(
    parameter int MAX_LEN = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,    // radix
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic [0:0]  s_axis_tuser,   // char_valid
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // value[63:0], end_position[76:64], zeros
    output logic        m_axis_tlast
);

    logic [itp_pkg::RADIX_W-1:0] radix_reg;
    itp_pkg::char_word_t         in_word;
    itp_pkg::char_word_t         head_word;
    logic                        head_valid;
    logic                        head_take;
    logic [itp_pkg::VALUE_W-1:0] out_value;
    logic [itp_pkg::END_W-1:0]   out_end_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= itp_pkg::RADIX_RESET;
        end
        else if (cfg_wr_en)
        begin
            radix_reg <= cfg_wr_data;
        end
    end

    assign in_word.char_valid = s_axis_tuser[0];
    assign in_word.char_code  = s_axis_tdata;
    assign in_word.is_last    = s_axis_tlast;

    itp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_word    (in_word),
        .head_valid (head_valid),
        .head_word  (head_word),
        .head_take  (head_take)
    );

    itp_core
    #(
        .MAX_LEN (MAX_LEN)
    )
    u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .radix       (radix_reg),
        .head_valid  (head_valid),
        .head_word   (head_word),
        .head_take   (head_take),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_value   (out_value),
        .out_end_pos (out_end_pos)
    );

    assign m_axis_tdata = {3'b000, out_end_pos, out_value};
    assign m_axis_tlast = 1'b1;

`ifndef SYNTHESIS
    // The skid register only fills behind a held head word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> head_valid)
        else $error("skid register full while head register is empty");

    // A new result appears only after a last word left the head register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready))
            |-> $past(head_valid && head_take && head_word.is_last))
        else $error("result without a last word");

    // The reported end position never passes the saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (MAX_LEN > 8191) || (int'(m_axis_tdata[76:64]) <= MAX_LEN))
        else $error("end position beyond limit");
`endif

endmodule
